### design/iso2ep_pkg.sv
// Shared constants, types and helpers for the timestamp-to-epoch converter.
package iso2ep_pkg;

    localparam int CHAR_W   = 8;
    localparam int EPOCH_W  = 39;
    localparam int POS_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int YADJ_W   = 14;
    localparam int DAYSA_W  = 22;
    localparam int DAYS_W   = 23;
    localparam int TOD_W    = 17;

    localparam logic [POS_W-1:0]   POS_LAST  = 5'd24;
    localparam logic [POS_W-1:0]   POS_SAT   = 5'd31;
    localparam logic [YADJ_W-1:0]  YEAR_BIAS = 14'd400;
    localparam logic [12:0]        RECIP_100 = 13'd5243;
    localparam logic [DAYS_W-1:0]  DAY_BIAS  = 23'd865566;

    localparam logic [CHAR_W-1:0]  CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0]  CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0]  CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_NINE  = 8'h39;

    typedef struct packed {
        logic take_char;
        logic final_char;
        logic prep;
        logic q100;
        logic q400;
        logic days_a;
        logic days;
        logic secs;
        logic local_sum;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Days from March 1 to the first of the month, March-based year.
    function automatic logic [8:0] month_doy(input logic [FIELD_W-1:0] month);
        logic [8:0] d;
        case (month)
            7'd3:    d = 9'd0;
            7'd4:    d = 9'd31;
            7'd5:    d = 9'd61;
            7'd6:    d = 9'd92;
            7'd7:    d = 9'd122;
            7'd8:    d = 9'd153;
            7'd9:    d = 9'd184;
            7'd10:   d = 9'd214;
            7'd11:   d = 9'd245;
            7'd12:   d = 9'd275;
            7'd1:    d = 9'd306;
            7'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### design/iso2ep_if.sv
// Handshake interfaces for the character input and the epoch result.
interface iso2ep_char_if;
    import iso2ep_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              final_char;
    modport source(output valid, text_char, final_char, input ready);
    modport sink(input valid, text_char, final_char, output ready);
endinterface

interface iso2ep_res_if;
    import iso2ep_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [EPOCH_W-1:0] epoch_seconds;
    modport source(output valid, ok, epoch_seconds, input ready);
    modport sink(input valid, ok, epoch_seconds, output ready);
endinterface

### design/iso8601_offset_to_epoch.sv
// Top level: ISO 8601 timestamp with zone offset to Unix epoch seconds.
// Characters are taken one per cycle while the block is receiving.
// After the final beat the conversion steps through year adjust, two reciprocal
// divides, two day sums, seconds multiply, local sum and result load; a timestamp
// is 25 characters, and the result load waits until the result register is free.
// Synchronous active-low reset returns all fields to zero and empties the result.
module iso8601_offset_to_epoch (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iso2ep_char_if.sink  i_char,
    iso2ep_res_if.source o_res
);
    import iso2ep_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    iso2ep_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_char.valid),
        .i_final_char (i_char.final_char),
        .o_in_ready   (i_char.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    iso2ep_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_text_char     (i_char.text_char),
        .o_out_valid     (o_res.valid),
        .i_out_ready     (o_res.ready),
        .o_ok            (o_res.ok),
        .o_epoch_seconds (o_res.epoch_seconds)
    );

endmodule

### design/iso2ep_ctrl.sv
// Controller: character intake and sequencing of the date conversion steps.
module iso2ep_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_final_char,
    output logic                   o_in_ready,
    input  iso2ep_pkg::t_dp_status i_status,
    output iso2ep_pkg::t_dp_cmd    o_cmd
);
    import iso2ep_pkg::*;

    localparam logic [3:0] S_RECV  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_Q100  = 4'd2;
    localparam logic [3:0] S_Q400  = 4'd3;
    localparam logic [3:0] S_DAYSA = 4'd4;
    localparam logic [3:0] S_DAYS  = 4'd5;
    localparam logic [3:0] S_SECS  = 4'd6;
    localparam logic [3:0] S_LOCAL = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_RECV: begin
                o_in_ready       = 1'b1;
                o_cmd.take_char  = i_in_valid;
                o_cmd.final_char = i_in_valid && i_final_char;
                if (i_in_valid && i_final_char) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_Q100;
            end
            S_Q100: begin
                o_cmd.q100 = 1'b1;
                n_state    = S_Q400;
            end
            S_Q400: begin
                o_cmd.q400 = 1'b1;
                n_state    = S_DAYSA;
            end
            S_DAYSA: begin
                o_cmd.days_a = 1'b1;
                n_state      = S_DAYS;
            end
            S_DAYS: begin
                o_cmd.days = 1'b1;
                n_state    = S_SECS;
            end
            S_SECS: begin
                o_cmd.secs = 1'b1;
                n_state    = S_LOCAL;
            end
            S_LOCAL: begin
                o_cmd.local_sum = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

endmodule

### design/iso2ep_dp.sv
// Datapath: field accumulators, range checks, epoch arithmetic, result register.
module iso2ep_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  iso2ep_pkg::t_dp_cmd                    i_cmd,
    output iso2ep_pkg::t_dp_status                 o_status,
    input  logic [iso2ep_pkg::CHAR_W-1:0]          i_text_char,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_ok,
    output logic signed [iso2ep_pkg::EPOCH_W-1:0]  o_epoch_seconds
);
    import iso2ep_pkg::*;

    // character intake state
    logic [POS_W-1:0]   r_pos;
    logic               r_err;
    logic               r_len_ok;
    logic [YEAR_W-1:0]  r_year;
    logic [FIELD_W-1:0] r_month;
    logic [FIELD_W-1:0] r_day;
    logic [FIELD_W-1:0] r_hour;
    logic [FIELD_W-1:0] r_minute;
    logic [FIELD_W-1:0] r_second;
    logic               r_neg;
    logic [FIELD_W-1:0] r_ohour;
    logic [FIELD_W-1:0] r_ominute;

    // conversion registers
    logic                       r_good;
    logic [YADJ_W-1:0]          r_y;
    logic [TOD_W-1:0]           r_tod;
    logic [TOD_W-1:0]           r_off;
    logic [6:0]                 r_q100;
    logic [4:0]                 r_q400;
    logic [DAYSA_W-1:0]         r_days_a;
    logic signed [DAYS_W-1:0]   r_days;
    logic signed [EPOCH_W-1:0]  r_secs;
    logic signed [EPOCH_W-1:0]  r_local;

    // result register
    logic                       r_out_valid;
    logic                       r_ok;
    logic signed [EPOCH_W-1:0]  r_epoch;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic                       n_good;
    logic [26:0]                prod_q100;
    logic [24:0]                prod_q400;
    logic signed [40:0]         prod_secs;
    logic                       local_m1;
    logic                       n_ok;
    logic signed [EPOCH_W-1:0]  n_epoch;
    logic                       out_take;

    function automatic logic [FIELD_W-1:0] fold7(input logic [FIELD_W-1:0] acc,
                                                input logic [3:0] d);
        return FIELD_W'(acc * FIELD_W'(10) + FIELD_W'(d));
    endfunction

    function automatic logic [YEAR_W-1:0] fold14(input logic [YEAR_W-1:0] acc,
                                                input logic [3:0] d);
        return YEAR_W'(acc * YEAR_W'(10) + YEAR_W'(d));
    endfunction

    assign is_digit = (i_text_char >= CH_ZERO) && (i_text_char <= CH_NINE);
    assign digit    = 4'(i_text_char - CH_ZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_pos     <= '0;
            r_err     <= 1'b0;
            r_len_ok  <= 1'b0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_neg     <= 1'b0;
            r_ohour   <= '0;
            r_ominute <= '0;
        end else if (i_cmd.take_char) begin
            if (r_pos != POS_SAT) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.final_char) begin
                r_len_ok <= (r_pos == POS_LAST);
            end
            case (r_pos) inside
                5'd0, 5'd1, 5'd2, 5'd3: begin
                    if (is_digit) r_year <= fold14(r_year, digit);
                    else          r_err  <= 1'b1;
                end
                5'd4, 5'd7: begin
                    if (i_text_char != CH_DASH) r_err <= 1'b1;
                end
                5'd5, 5'd6: begin
                    if (is_digit) r_month <= fold7(r_month, digit);
                    else          r_err   <= 1'b1;
                end
                5'd8, 5'd9: begin
                    if (is_digit) r_day <= fold7(r_day, digit);
                    else          r_err <= 1'b1;
                end
                5'd10: begin
                    if (i_text_char != CH_T) r_err <= 1'b1;
                end
                5'd11, 5'd12: begin
                    if (is_digit) r_hour <= fold7(r_hour, digit);
                    else          r_err  <= 1'b1;
                end
                5'd13, 5'd16, 5'd22: begin
                    if (i_text_char != CH_COLON) r_err <= 1'b1;
                end
                5'd14, 5'd15: begin
                    if (is_digit) r_minute <= fold7(r_minute, digit);
                    else          r_err    <= 1'b1;
                end
                5'd17, 5'd18: begin
                    if (is_digit) r_second <= fold7(r_second, digit);
                    else          r_err    <= 1'b1;
                end
                5'd19: begin
                    if (i_text_char == CH_DASH)      r_neg <= 1'b1;
                    else if (i_text_char != CH_PLUS) r_err <= 1'b1;
                end
                5'd20, 5'd21: begin
                    if (is_digit) r_ohour <= fold7(r_ohour, digit);
                    else          r_err   <= 1'b1;
                end
                5'd23, 5'd24: begin
                    if (is_digit) r_ominute <= fold7(r_ominute, digit);
                    else          r_err     <= 1'b1;
                end
                default: begin
                    r_err <= 1'b1;
                end
            endcase
        end
    end

    assign n_good = r_len_ok && !r_err &&
                    (r_month >= 7'd1) && (r_month <= 7'd12) &&
                    (r_day >= 7'd1) && (r_day <= 7'd31) &&
                    (r_hour <= 7'd23) && (r_minute <= 7'd59) && (r_second <= 7'd59) &&
                    (r_ohour <= 7'd23) && (r_ominute <= 7'd59);

    // divide by 100 through a reciprocal, exact for the year range used here
    assign prod_q100 = 27'(r_y) * 27'(RECIP_100);
    assign prod_q400 = 25'(r_y[YADJ_W-1:2]) * 25'(RECIP_100);
    assign prod_secs = 41'(r_days) * 41'(18'sd86400);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_good <= n_good;
            r_y    <= r_year + YEAR_BIAS - ((r_month <= 7'd2) ? 14'd1 : 14'd0);
            r_tod  <= TOD_W'(r_hour * TOD_W'(3600)) + TOD_W'(r_minute * TOD_W'(60))
                      + TOD_W'(r_second);
        end
        if (i_cmd.q100) begin
            r_q100 <= prod_q100[25:19];
            r_off  <= TOD_W'(r_ohour * TOD_W'(3600)) + TOD_W'(r_ominute * TOD_W'(60));
        end
        if (i_cmd.q400) begin
            r_q400 <= prod_q400[23:19];
        end
        if (i_cmd.days_a) begin
            r_days_a <= DAYSA_W'(r_y * DAYSA_W'(365)) + DAYSA_W'(r_y[YADJ_W-1:2])
                        - DAYSA_W'(r_q100) + DAYSA_W'(r_q400);
        end
        if (i_cmd.days) begin
            r_days <= $signed({1'b0, r_days_a})
                      + $signed(DAYS_W'(month_doy(r_month)) + DAYS_W'(r_day))
                      - $signed(DAY_BIAS);
        end
        if (i_cmd.secs) begin
            r_secs <= prod_secs[EPOCH_W-1:0];
        end
        if (i_cmd.local_sum) begin
            r_local <= r_secs + $signed({{(EPOCH_W-TOD_W){1'b0}}, r_tod});
        end
    end

    assign local_m1 = (r_local == {EPOCH_W{1'b1}});
    assign n_ok     = r_good && !local_m1;

    always_comb begin
        n_epoch = '0;
        if (n_ok) begin
            if (r_neg) n_epoch = r_local + $signed({{(EPOCH_W-TOD_W){1'b0}}, r_off});
            else       n_epoch = r_local - $signed({{(EPOCH_W-TOD_W){1'b0}}, r_off});
        end
    end

    assign out_take          = r_out_valid && i_out_ready;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ok    <= n_ok;
            r_epoch <= n_epoch;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_epoch_seconds = r_epoch;

endmodule
